### hdl/nearest_point_search_2d_assert.svh
// assertion helpers shared by the search block
`ifndef NEAREST_POINT_SEARCH_2D_ASSERT_SVH
`define NEAREST_POINT_SEARCH_2D_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define NPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define NPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/nps_pkg.sv
`default_nettype none
package nps_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	localparam int COORD_W    = 16;
	localparam int MAG_W      = COORD_W;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int DIST_W     = SQ_W + 1;
	localparam int ENTRY_W    = 6;
	localparam int EXCL_W     = 7;
	localparam int CFG_W      = 7;
	localparam int OUT_IDX_W  = 6;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} nps_state_t;

	// control that travels alongside one entry through the distance pipeline
	typedef struct packed {
		logic             vld;
		logic             use_entry;
		logic             last;
		logic [IDX_W-1:0] idx;
	} nps_tag_t;

endpackage
`default_nettype wire

### hdl/nps_cell.sv
`default_nettype none
module nps_cell
	import nps_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               load,
	input  wire logic [COORD_W-1:0] load_x,
	input  wire logic [COORD_W-1:0] load_y,
	input  wire logic               shift,
	input  wire logic [COORD_W-1:0] next_x,
	input  wire logic [COORD_W-1:0] next_y,
	output logic      [COORD_W-1:0] x,
	output logic      [COORD_W-1:0] y
);

	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= load_x;
			y_q <= load_y;
		end else if (shift) begin
			x_q <= next_x;
			y_q <= next_y;
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule
`default_nettype wire

### hdl/nps_dist.sv
`default_nettype none
module nps_dist
	import nps_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire nps_tag_t           tag_in,
	input  wire logic [COORD_W-1:0] px,
	input  wire logic [COORD_W-1:0] py,
	input  wire logic [COORD_W-1:0] qx,
	input  wire logic [COORD_W-1:0] qy,
	output nps_tag_t                tag_out,
	output logic      [DIST_W-1:0]  dist_out
);

	logic signed [COORD_W:0] dx;
	logic signed [COORD_W:0] dy;
	logic        [COORD_W:0] dx_neg;
	logic        [COORD_W:0] dy_neg;
	logic        [MAG_W-1:0] mag_x;
	logic        [MAG_W-1:0] mag_y;

	nps_tag_t          tag_s1, tag_s2, tag_s3;
	logic [MAG_W-1:0]  mag_x_s1, mag_y_s1;
	logic [SQ_W-1:0]   sq_x_s2, sq_y_s2;
	logic [DIST_W-1:0] dist_s3;

	// difference fits 17 bits signed, its magnitude fits 16 bits unsigned
	always_comb begin
		dx     = $signed({px[COORD_W-1], px}) - $signed({qx[COORD_W-1], qx});
		dy     = $signed({py[COORD_W-1], py}) - $signed({qy[COORD_W-1], qy});
		dx_neg = -dx;
		dy_neg = -dy;
		mag_x  = dx[COORD_W] ? dx_neg[MAG_W-1:0] : dx[MAG_W-1:0];
		mag_y  = dy[COORD_W] ? dy_neg[MAG_W-1:0] : dy[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		mag_x_s1 <= mag_x;
		mag_y_s1 <= mag_y;
		sq_x_s2  <= SQ_W'(mag_x_s1) * SQ_W'(mag_x_s1);
		sq_y_s2  <= SQ_W'(mag_y_s1) * SQ_W'(mag_y_s1);
		dist_s3  <= DIST_W'(sq_x_s2) + DIST_W'(sq_y_s2);
	end

	assign tag_out  = tag_s3;
	assign dist_out = dist_s3;

endmodule
`default_nettype wire

### hdl/nearest_point_search_2d.sv
`default_nettype none
// Nearest point search over a table of up to 64 stored 2D points (signed Q8.8).
// A write request (op 0) loads one table slot and returns index 0, found 0 at
// once. A query request (op 1) rotates the ring of point cells one full turn,
// one entry a cycle past a three-stage squared-distance pipeline, and keeps
// the closest of the first camera_count entries, skipping exclude_index; ties
// go to the lower index. A query turns the ring, then drains the pipeline and
// loads the result; a write is answered without a scan. The input is stalled
// while a query runs and while a finished result still waits in the output
// register. The user must see that camera_count is written through the cfg
// port only while the block is idle; the block itself does not enforce it.
module nearest_point_search_2d
	import nps_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,

	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_W-1:0]          cfg_data,

	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      op,
	input  wire logic [ENTRY_W-1:0]        entry_index,
	input  wire logic signed [COORD_W-1:0] pos_x,
	input  wire logic signed [COORD_W-1:0] pos_y,
	input  wire logic signed [EXCL_W-1:0]  exclude_index,

	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [OUT_IDX_W-1:0]           nearest_index,
	output logic                           found
);

`include "nearest_point_search_2d_assert.svh"

	nps_state_t state_q, state_d;

	logic [CFG_W-1:0]   camera_count_q;
	logic [CNT_W-1:0]   count_eff;
	logic [IDX_W-1:0]   scan_cnt_q;
	logic [COORD_W-1:0] qx_q, qy_q;
	logic [EXCL_W-1:0]  excl_q;

	logic               out_valid_q;
	logic [OUT_IDX_W-1:0] out_idx_q;
	logic               out_found_q;

	logic [DIST_W-1:0]  best_d_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic               best_found_q;

	logic               out_free;
	logic               accept;
	logic               write_acc;
	logic               query_acc;
	logic               scan_en;
	logic               scan_last;
	logic               result_load;

	logic [COORD_W-1:0] cell_x [MAX_POINTS];
	logic [COORD_W-1:0] cell_y [MAX_POINTS];

	nps_tag_t           tag_in;
	nps_tag_t           tag_s3;
	logic [DIST_W-1:0]  dist_s3;
	logic               better;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign accept    = in_valid && !in_stall;
	assign write_acc = accept && (op == OP_WRITE);
	assign query_acc = accept && (op == OP_QUERY);
	assign scan_last = scan_cnt_q == IDX_W'(MAX_POINTS - 1);

	always_comb begin
		count_eff = (int'(camera_count_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
		                                                : CNT_W'(camera_count_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (query_acc) state_d = ST_SCAN;
			ST_SCAN:  if (scan_last) state_d = ST_DRAIN;
			ST_DRAIN: if (tag_s3.vld && tag_s3.last) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		in_stall    = 1'b1;
		scan_en     = 1'b0;
		result_load = 1'b0;
		case (state_q)
			ST_IDLE:  in_stall    = !out_free;
			ST_SCAN:  scan_en     = 1'b1;
			ST_DRAIN: scan_en     = 1'b0;
			ST_DONE:  result_load = out_free;
			default:  in_stall    = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			camera_count_q <= '0;
			scan_cnt_q     <= '0;
			out_valid_q    <= 1'b0;
			best_found_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				camera_count_q <= cfg_data;
			end
			if (query_acc) begin
				scan_cnt_q <= '0;
			end else if (scan_en) begin
				scan_cnt_q <= scan_cnt_q + IDX_W'(1);
			end
			if (query_acc) begin
				best_found_q <= 1'b0;
			end else if (better) begin
				best_found_q <= 1'b1;
			end
			if (write_acc || result_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			qx_q       <= pos_x;
			qy_q       <= pos_y;
			excl_q     <= exclude_index;
			best_idx_q <= '0;
		end else if (better) begin
			best_idx_q <= tag_s3.idx;
		end
		if (better) begin
			best_d_q <= dist_s3;
		end
		if (write_acc) begin
			out_idx_q   <= '0;
			out_found_q <= 1'b0;
		end else if (result_load) begin
			out_idx_q   <= OUT_IDX_W'(best_idx_q);
			out_found_q <= best_found_q;
		end
	end

	// ring of point cells, rotating toward cell 0 during a scan
	for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
		nps_cell u_cell (
			.clk    (clk),
			.load   (write_acc && (int'(entry_index) == k)),
			.load_x (pos_x),
			.load_y (pos_y),
			.shift  (scan_en),
			.next_x (cell_x[(k + 1) % MAX_POINTS]),
			.next_y (cell_y[(k + 1) % MAX_POINTS]),
			.x      (cell_x[k]),
			.y      (cell_y[k])
		);
	end

	// cell 0 holds entry scan_cnt_q during a scan
	always_comb begin
		tag_in.vld       = scan_en;
		tag_in.last      = scan_last;
		tag_in.idx       = scan_cnt_q;
		tag_in.use_entry = ({1'b0, scan_cnt_q} < (IDX_W + 1)'(count_eff))
			&& !(!excl_q[EXCL_W-1] && (int'(excl_q) == int'(scan_cnt_q)));
	end

	nps_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_in   (tag_in),
		.px       (cell_x[0]),
		.py       (cell_y[0]),
		.qx       (qx_q),
		.qy       (qy_q),
		.tag_out  (tag_s3),
		.dist_out (dist_s3)
	);

	// strict less-than keeps the lower index on a tie
	assign better = tag_s3.vld && tag_s3.use_entry && (!best_found_q || (dist_s3 < best_d_q));

	assign out_valid     = out_valid_q;
	assign nearest_index = out_idx_q;
	assign found         = out_found_q;

	`NPS_ASSERT_NEXT(a_scan_ends, clk, arst_n, (state_q == ST_SCAN) && scan_last,
		state_q == ST_DRAIN, "scan did not end after a full ring turn")
	`NPS_ASSERT_NEXT(a_drain_ends, clk, arst_n, (state_q == ST_DRAIN) && tag_s3.vld && tag_s3.last,
		state_q == ST_DONE, "drain did not end with the last entry")
	`NPS_ASSERT_NOW(a_none_is_zero, clk, arst_n, out_valid_q && !out_found_q,
		out_idx_q == '0, "result without a match carries a nonzero index")
	`NPS_ASSERT_NOW(a_idx_in_range, clk, arst_n, (state_q == ST_DONE) && best_found_q,
		int'(best_idx_q) < int'(count_eff), "best entry lies beyond the searched count")

endmodule
`default_nettype wire

### verif/nearest_point_search_2d_check.sv
`timescale 1ns / 100ps
module nearest_point_search_2d_check
	import nps_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,

	input  wire logic                      cfg_valid,
	input  wire logic                      cfg_ready,
	input  wire logic [CFG_W-1:0]          cfg_data,

	input  wire logic                      in_valid,
	input  wire logic                      in_stall,
	input  wire logic                      op,
	input  wire logic [ENTRY_W-1:0]        entry_index,
	input  wire logic signed [COORD_W-1:0] pos_x,
	input  wire logic signed [COORD_W-1:0] pos_y,
	input  wire logic signed [EXCL_W-1:0]  exclude_index,

	input  wire logic                      out_valid,
	input  wire logic                      out_stall,
	input  wire logic [OUT_IDX_W-1:0]      nearest_index,
	input  wire logic                      found,

	output int                             errors,
	output int                             pending
);

	typedef struct packed {
		logic [OUT_IDX_W-1:0] index;
		logic                 hit;
	} answer_t;

	logic signed [COORD_W-1:0] point_x [MAX_POINTS];
	logic signed [COORD_W-1:0] point_y [MAX_POINTS];
	logic [CFG_W-1:0]          search_count;
	answer_t                   answers_due [$];

	// linear scan, strict less-than keeps the lowest index on a tie
	function automatic answer_t nearest_of(input logic signed [COORD_W-1:0] qx,
			input logic signed [COORD_W-1:0] qy, input logic signed [EXCL_W-1:0] skip);
		answer_t a;
		longint  dx;
		longint  dy;
		longint  d;
		longint  best_d;
		int      n;
		a = '0;
		best_d = 0;
		n = (search_count > MAX_POINTS) ? MAX_POINTS : int'(search_count);
		for (int i = 0; i < n; i++) begin
			if (skip >= 0 && int'(skip) == i)
				continue;
			dx = longint'(point_x[i]) - longint'(qx);
			dy = longint'(point_y[i]) - longint'(qy);
			d = dx * dx + dy * dy;
			if (!a.hit || d < best_d) begin
				best_d = d;
				a.index = OUT_IDX_W'(i);
				a.hit = 1'b1;
			end
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			foreach (point_x[i]) begin
				point_x[i] = '0;
				point_y[i] = '0;
			end
			search_count = '0;
			answers_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				search_count = cfg_data;

			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					$error("result with no request waiting: nearest_index %0d, found %0d",
						nearest_index, found);
					errors++;
				end else begin
					want = answers_due.pop_front();
					if (nearest_index !== want.index) begin
						$error("nearest_index: expected %0d, actual %0d",
							want.index, nearest_index);
						errors++;
					end
					if (found !== want.hit) begin
						$error("found: expected %0d, actual %0d", want.hit, found);
						errors++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				if (op == OP_WRITE) begin
					point_x[entry_index] = pos_x;
					point_y[entry_index] = pos_y;
					answers_due.insert(answers_due.size(), answer_t'('0));
				end else begin
					answers_due.insert(answers_due.size(),
						nearest_of(pos_x, pos_y, exclude_index));
				end
			end

			pending = answers_due.size();
		end
	end

endmodule

### verif/nearest_point_search_2d_test.sv
`timescale 1ns / 100ps
module nearest_point_search_2d_test
	import nps_pkg::*;
();

	localparam int HALF_PERIOD = 10;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 90;

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      cfg_valid     = 1'b0;
	logic [CFG_W-1:0]          cfg_data      = '0;
	logic                      in_valid      = 1'b0;
	logic                      op            = OP_WRITE;
	logic [ENTRY_W-1:0]        entry_index   = '0;
	logic signed [COORD_W-1:0] pos_x         = '0;
	logic signed [COORD_W-1:0] pos_y         = '0;
	logic signed [EXCL_W-1:0]  exclude_index = '0;
	logic                      out_stall     = 1'b0;

	wire logic                 cfg_ready;
	wire logic                 in_stall;
	wire logic                 out_valid;
	wire logic [OUT_IDX_W-1:0] nearest_index;
	wire logic                 found;

	int   errors;
	int   pending;
	int   cycles       = 0;
	int   hold_left    = 0;
	int   active_count = 0;
	logic rx_taken     = 1'b0;
	logic armed        = 1'b0;
	logic quiet        = 1'b0;

	// positions last written, used to aim queries near stored points
	logic signed [COORD_W-1:0] table_x [MAX_POINTS];
	logic signed [COORD_W-1:0] table_y [MAX_POINTS];

	nearest_point_search_2d dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.entry_index   (entry_index),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.exclude_index (exclude_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.nearest_index (nearest_index),
		.found         (found)
	);

	nearest_point_search_2d_check answer_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.entry_index   (entry_index),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.exclude_index (exclude_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.nearest_index (nearest_index),
		.found         (found),
		.errors        (errors),
		.pending       (pending)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("nearest_point_search_2d_test: done, errors");
			$finish;
		end
	end

	function automatic int draw_wait();
		if (quiet)
			return 0;
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic logic signed [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return COORD_W'($urandom);
			1: return COORD_W'($urandom_range(0, 16) - 8);
			2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: return COORD_W'($urandom_range(0, 2000) - 1000);
		endcase
	endfunction

	// result side: one stall draw per result, starting when it shows up
	always @(posedge clk) rx_taken <= out_valid && !out_stall;

	always @(negedge clk) begin
		int   w;
		logic fresh;
		fresh = out_valid && (rx_taken || !armed);
		if (fresh) begin
			w = draw_wait();
			armed <= 1'b1;
			out_stall <= (w != 0);
			hold_left <= (w > 1) ? w - 1 : 0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (rx_taken)
				armed <= 1'b0;
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(input logic kind, input logic [ENTRY_W-1:0] slot,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
			input logic signed [EXCL_W-1:0] skip);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		entry_index <= slot;
		pos_x <= x;
		pos_y <= y;
		exclude_index <= skip;
		if (kind == OP_WRITE) begin
			table_x[slot] = x;
			table_y[slot] = y;
		end
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// count changes only once every request has come back
	task automatic set_count(input int n);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= CFG_W'(n);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		active_count = n;
	endtask

	initial begin
		int                        n;
		int                        s;
		int                        span;
		logic signed [COORD_W-1:0] qx;
		logic signed [COORD_W-1:0] qy;
		logic signed [EXCL_W-1:0]  skip;

		foreach (table_x[i]) begin
			table_x[i] = '0;
			table_y[i] = '0;
		end
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty search after reset
		send_request(OP_QUERY, '0, '0, '0, EXCL_W'(-1));
		send_request(OP_QUERY, 6'd63, 16'sh7FFF, 16'sh8000, EXCL_W'(63));

		// fill the whole table: corners, a tied pair, the rest random
		for (int k = 0; k < MAX_POINTS; k++) begin
			case (k)
				0: begin qx = 16'sh8000; qy = 16'sh8000; end
				1: begin qx = 16'sh7FFF; qy = 16'sh7FFF; end
				2, 3: begin qx = 16'sd100; qy = -16'sd100; end
				default: begin qx = pick_coord(); qy = pick_coord(); end
			endcase
			send_request(OP_WRITE, ENTRY_W'(k), qx, qy, EXCL_W'($urandom));
		end

		set_count(64);
		send_request(OP_QUERY, '0, 16'sh7FFF, 16'sh7FFF, EXCL_W'(-1));
		send_request(OP_QUERY, '0, 16'sh7FFF, 16'sh7FFF, EXCL_W'(1));
		send_request(OP_QUERY, '0, 16'sh8000, 16'sh8000, EXCL_W'(-64));
		send_request(OP_QUERY, '0, 16'sd100, -16'sd100, EXCL_W'(-1));
		send_request(OP_QUERY, '0, 16'sd100, -16'sd100, EXCL_W'(2));
		send_request(OP_QUERY, 6'd63, 16'sh7FFF, 16'sh8000, EXCL_W'(63));

		// single entry excluded leaves nothing to search
		set_count(1);
		send_request(OP_QUERY, '0, '0, '0, EXCL_W'(0));
		send_request(OP_QUERY, '0, '0, '0, EXCL_W'(-1));

		// exclude beyond the count excludes nothing
		set_count(2);
		send_request(OP_QUERY, '0, 16'sd100, -16'sd100, EXCL_W'(5));

		// count above the table saturates
		set_count(127);
		send_request(OP_QUERY, '0, '0, '0, EXCL_W'(-1));
		send_request(OP_QUERY, '0, 16'sh8000, 16'sh7FFF, EXCL_W'(0));

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: n = 64;
				1: n = 65;
				2: n = 0;
				3: n = 3;
				4: n = 100;
				default: n = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(0, 127);
			endcase
			set_count(n);
			quiet = (p % 4 == 3);
			span = (active_count > MAX_POINTS) ? MAX_POINTS : active_count;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					s = $urandom_range(0, MAX_POINTS - 1);
					if ($urandom_range(0, 3) == 0) begin
						// duplicate a stored point to make ties
						qx = table_x[s];
						qy = table_y[s];
					end else begin
						qx = pick_coord();
						qy = pick_coord();
					end
					send_request(OP_WRITE, ENTRY_W'($urandom), qx, qy, EXCL_W'($urandom));
				end else begin
					s = (span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, MAX_POINTS - 1);
					if ($urandom_range(0, 4) != 0) begin
						qx = table_x[s] + COORD_W'($urandom_range(0, 6) - 3);
						qy = table_y[s] + COORD_W'($urandom_range(0, 6) - 3);
					end else begin
						qx = pick_coord();
						qy = pick_coord();
					end
					case ($urandom_range(0, 5))
						0, 1: skip = EXCL_W'(s);
						2: skip = EXCL_W'(-1);
						3: skip = EXCL_W'($urandom_range(64, 127));
						default: skip = EXCL_W'($urandom_range(0, 63));
					endcase
					send_request(OP_QUERY, ENTRY_W'($urandom), qx, qy, skip);
				end
			end
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
		if (errors == 0)
			$display("nearest_point_search_2d_test: done, clean");
		else
			$display("nearest_point_search_2d_test: done, errors");
		$finish;
	end

endmodule
